// ===== design/gwm_pkg.sv =====
// Shared types, constants and neighbor tables for the grid walkability map.
// No dependencies; imported by every module of the block except gwm_ram.
package gwm_pkg;

    localparam int COORD_W = 16;
    localparam int DIM_W   = 9;
    localparam int EXT_W   = 18;
    localparam int ID_W    = 17;
    localparam int COST_W  = 4;
    localparam int DIST_W  = 21;
    localparam int OP_W    = 3;
    localparam int NB_N    = 8;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_FILL   = 3'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 3'd2;
    localparam logic [OP_W-1:0] OP_EXPAND = 3'd3;
    localparam logic [OP_W-1:0] OP_DIST   = 3'd4;

    localparam logic [COST_W-1:0] COST_STRAIGHT = 4'd10;
    localparam logic [COST_W-1:0] COST_DIAG     = 4'd14;

    // register select bit of paddr
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        CMD_CLEAR,
        CMD_FILL,
        CMD_QUERY,
        CMD_EXPAND,
        CMD_DIST
    } cmd_kind_t;

    // classified command handed from front to back
    typedef struct packed {
        cmd_kind_t              kind;
        logic [DIM_W-1:0]       x;
        logic [DIM_W-1:0]       y;
        logic [NB_N-1:0]        inb;
        logic                   qok;
        logic [DIM_W-1:0]       fx0;
        logic [DIM_W-1:0]       fx1;
        logic [DIM_W-1:0]       fy0;
        logic [DIM_W-1:0]       fy1;
        logic                   fval;
        logic [EXT_W-1:0]       dsum;
    } cmd_t;

    typedef struct packed {
        logic                   walkable;
        logic                   nvalid;
        logic [ID_W-1:0]        id;
        logic [COST_W-1:0]      cost;
        logic [DIST_W-1:0]      dist_x10;
        logic                   last;
    } result_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL_SETUP,
        ST_FILL,
        ST_QRY_READ,
        ST_QRY_RESP,
        ST_EXP_READ,
        ST_EXP_WAIT,
        ST_EXP_EMIT,
        ST_DIST
    } back_state_t;

    // neighbor k: column index 0..2 stands for offset -1..1 (column outer)
    function automatic logic [1:0] nb_col(input logic [2:0] k);
        logic [1:0] c;
        case (k)
            3'd0, 3'd1, 3'd2: c = 2'd0;
            3'd3, 3'd4:       c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

    // neighbor k: row index 0..2 (row inner, center skipped)
    function automatic logic [1:0] nb_row(input logic [2:0] k);
        logic [1:0] r;
        case (k)
            3'd0, 3'd3, 3'd5: r = 2'd0;
            3'd1, 3'd6:       r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [COST_W-1:0] nb_cost(input logic [2:0] k);
        logic [COST_W-1:0] c;
        case (k)
            3'd0, 3'd2, 3'd5, 3'd7: c = COST_DIAG;
            default:                c = COST_STRAIGHT;
        endcase
        return c;
    endfunction

endpackage

// ===== design/gwm_ram.sv =====
// Generic single-bit-or-wider RAM: one write port, one registered read port.
// No dependencies.
module gwm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536,
    parameter int ADDR_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/gwm_front.sv =====
// Front end: accepts items, classifies them, clips fill rectangles, checks
// neighbor bounds, sums distances, and holds commands in a two-entry queue.
// Depends on gwm_pkg.
module gwm_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [gwm_pkg::OP_W-1:0]      op,
    input  logic signed [gwm_pkg::COORD_W-1:0] x_coord,
    input  logic signed [gwm_pkg::COORD_W-1:0] y_coord,
    input  logic                          above_ground,
    input  logic [gwm_pkg::COORD_W-1:0]   half_width,
    input  logic [gwm_pkg::COORD_W-1:0]   half_height,
    input  logic                          fill_value,
    input  logic signed [gwm_pkg::COORD_W-1:0] goal_x,
    input  logic signed [gwm_pkg::COORD_W-1:0] goal_y,
    input  logic [gwm_pkg::DIM_W-1:0]     eff_w,
    input  logic [gwm_pkg::DIM_W-1:0]     eff_h,
    input  logic                          hold,
    input  logic                          q_pop,
    output logic                          q_empty,
    output gwm_pkg::cmd_t                 q_head
);
    import gwm_pkg::*;

    logic signed [EXT_W-1:0] sx, sy, sgx, sgy, sw, sh, wm1, hm1;
    logic signed [EXT_W-1:0] x0, x1, y0, y1, x0c, x1c, y0c, y1c;
    logic signed [EXT_W-1:0] ax, ay, xc, yc;
    logic [2:0]              col_ok, row_ok;
    logic                    fill_empty, keep, accept;
    cmd_t                    cmd;

    cmd_t       q_mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    // sign/zero extension to a common width
    always_comb
    begin
        sx  = EXT_W'(x_coord);
        sy  = EXT_W'(y_coord);
        sgx = EXT_W'(goal_x);
        sgy = EXT_W'(goal_y);
        sw  = $signed(EXT_W'(eff_w));
        sh  = $signed(EXT_W'(eff_h));
        wm1 = sw - 18'sd1;
        hm1 = sh - 18'sd1;
    end

    // fill rectangle clipped to the map
    always_comb
    begin
        x0  = sx - $signed(EXT_W'(half_width));
        x1  = sx + $signed(EXT_W'(half_width));
        y0  = sy - $signed(EXT_W'(half_height));
        y1  = sy + $signed(EXT_W'(half_height));
        x0c = (x0 < 0) ? '0 : x0;
        y0c = (y0 < 0) ? '0 : y0;
        x1c = (x1 > wm1) ? wm1 : x1;
        y1c = (y1 > hm1) ? hm1 : y1;
        fill_empty = (x0c > x1c) || (y0c > y1c);
    end

    // neighbor column/row bounds
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            xc = sx + EXT_W'(c) - 18'sd1;
            yc = sy + EXT_W'(c) - 18'sd1;
            col_ok[c] = (xc >= 0) && (xc < sw);
            row_ok[c] = (yc >= 0) && (yc < sh);
        end
    end

    // Manhattan distance (times ten applied in the back end)
    always_comb
    begin
        ax = (sx > sgx) ? (sx - sgx) : (sgx - sx);
        ay = (sy > sgy) ? (sy - sgy) : (sgy - sy);
    end

    // classify
    always_comb
    begin
        cmd.x    = x_coord[DIM_W-1:0];
        cmd.y    = y_coord[DIM_W-1:0];
        for (int k = 0; k < NB_N; k++)
        begin
            cmd.inb[k] = col_ok[nb_col(3'(k))] && row_ok[nb_row(3'(k))];
        end
        cmd.qok  = !above_ground && col_ok[1] && row_ok[1];
        cmd.fx0  = x0c[DIM_W-1:0];
        cmd.fx1  = x1c[DIM_W-1:0];
        cmd.fy0  = y0c[DIM_W-1:0];
        cmd.fy1  = y1c[DIM_W-1:0];
        cmd.fval = fill_value;
        cmd.dsum = EXT_W'(ax + ay);
        cmd.kind = CMD_CLEAR;
        keep     = 1'b0;
        case (op)
            OP_CLEAR:
            begin
                cmd.kind = CMD_CLEAR;
                keep     = 1'b1;
            end
            OP_FILL:
            begin
                cmd.kind = CMD_FILL;
                keep     = !above_ground && !fill_empty;
            end
            OP_QUERY:
            begin
                cmd.kind = CMD_QUERY;
                keep     = 1'b1;
            end
            OP_EXPAND:
            begin
                cmd.kind = CMD_EXPAND;
                keep     = 1'b1;
            end
            OP_DIST:
            begin
                cmd.kind = CMD_DIST;
                keep     = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign full    = (cnt_reg == 2'd2) || hold;
    assign accept  = push && !full;
    assign q_empty = (cnt_reg == 2'd0);
    assign q_head  = q_mem_reg[rd_ptr_reg];

    // command queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (accept && keep)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'((accept && keep) ? 1 : 0) - 2'(q_pop ? 1 : 0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

// ===== design/gwm_back.sv =====
// Back end: sequencer that sweeps, fills, reads and expands over the map RAM,
// and a four-entry result queue. Depends on gwm_pkg and gwm_ram.
module gwm_back #(
    parameter int MAX_WIDTH  = gwm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gwm_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [gwm_pkg::DIM_W-1:0]   eff_w,
    input  logic                        q_empty,
    input  gwm_pkg::cmd_t               q_head,
    output logic                        q_pop,
    output logic                        hold,
    input  logic                        pop,
    output logic                        empty,
    output gwm_pkg::result_t            res
);
    import gwm_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = 2 * DIM_W + 1;

    back_state_t       state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [ADDR_W-1:0] addr_reg, addr_next, row_reg, row_next;
    logic [DIM_W-1:0]  cx_reg, cx_next, cy_reg, cy_next;
    logic [2:0]        k_reg, k_next, rd_k_reg, rd_k_next;
    logic [NB_N-1:0]   mask_reg, mask_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              init_reg, init_next;

    logic [DIM_W-1:0]  a_x, a_y;
    logic [IDX_W-1:0]  idx;
    logic              ram_we, ram_re, ram_wdata, ram_rdata;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic              k_last;

    result_t           rs;
    logic              rpush, room;
    result_t           of_mem_reg [4];
    logic [1:0]        of_wp_reg, of_rp_reg;
    logic [2:0]        of_cnt_reg;
    logic              opop;

    gwm_ram #(
        .WIDTH  (1),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign room   = (of_cnt_reg != 3'd4);
    assign hold   = init_reg;
    // no passable neighbor above index k
    assign k_last = ((mask_reg >> k_reg) >> 1) == '0;

    // shared cell index: y*width + x
    always_comb
    begin
        case (state_reg)
            ST_FILL_SETUP:
            begin
                a_x = cmd_reg.fx0;
                a_y = cmd_reg.fy0;
            end
            ST_QRY_READ:
            begin
                a_x = cmd_reg.x;
                a_y = cmd_reg.y;
            end
            default:
            begin
                a_x = cmd_reg.x + DIM_W'(nb_col(k_reg)) - DIM_W'(1);
                a_y = cmd_reg.y + DIM_W'(nb_row(k_reg)) - DIM_W'(1);
            end
        endcase
        idx = IDX_W'(a_y) * IDX_W'(eff_w) + IDX_W'(a_x);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_head.kind)
                        CMD_CLEAR:  state_next = ST_CLEAR;
                        CMD_FILL:   state_next = ST_FILL_SETUP;
                        CMD_QUERY:  state_next = ST_QRY_READ;
                        CMD_EXPAND: state_next = ST_EXP_READ;
                        CMD_DIST:   state_next = ST_DIST;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FILL_SETUP:
            begin
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                if (cx_reg == cmd_reg.fx1 && cy_reg == cmd_reg.fy1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_QRY_READ:
            begin
                state_next = ST_QRY_RESP;
            end
            ST_QRY_RESP, ST_DIST:
            begin
                if (room)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EXP_READ:
            begin
                if (k_reg == 3'd7)
                begin
                    state_next = ST_EXP_WAIT;
                end
            end
            ST_EXP_WAIT:
            begin
                state_next = ST_EXP_EMIT;
            end
            ST_EXP_EMIT:
            begin
                if (room && (mask_reg == '0 || (mask_reg[k_reg] && k_last)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_next     = cmd_reg;
        addr_next    = addr_reg;
        row_next     = row_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        k_next       = k_reg;
        rd_k_next    = k_reg;
        mask_next    = mask_reg;
        rd_pend_next = 1'b0;
        init_next    = init_reg;
        q_pop        = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = addr_reg;
        ram_wdata    = 1'b1;
        ram_re       = 1'b0;
        ram_raddr    = ADDR_W'(idx);
        rpush        = 1'b0;
        rs           = '0;

        // capture of a neighbor read issued last cycle
        if (rd_pend_reg)
        begin
            mask_next[rd_k_reg] = ram_rdata;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = 1'b1;
                addr_next = addr_reg + ADDR_W'(1);
                if (addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    init_next = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    cmd_next  = q_head;
                    addr_next = '0;
                    k_next    = 3'd0;
                    mask_next = '0;
                end
            end
            ST_FILL_SETUP:
            begin
                row_next  = ADDR_W'(idx);
                addr_next = ADDR_W'(idx);
                cx_next   = cmd_reg.fx0;
                cy_next   = cmd_reg.fy0;
            end
            ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_wdata = cmd_reg.fval;
                if (cx_reg == cmd_reg.fx1)
                begin
                    row_next  = row_reg + ADDR_W'(eff_w);
                    addr_next = row_reg + ADDR_W'(eff_w);
                    cx_next   = cmd_reg.fx0;
                    cy_next   = cy_reg + DIM_W'(1);
                end
                else
                begin
                    addr_next = addr_reg + ADDR_W'(1);
                    cx_next   = cx_reg + DIM_W'(1);
                end
            end
            ST_QRY_READ:
            begin
                ram_re = cmd_reg.qok;
            end
            ST_QRY_RESP:
            begin
                rpush       = room;
                rs.walkable = cmd_reg.qok && ram_rdata;
                rs.last     = 1'b1;
            end
            ST_EXP_READ:
            begin
                ram_re       = cmd_reg.inb[k_reg];
                rd_pend_next = cmd_reg.inb[k_reg];
                k_next       = k_reg + 3'd1;
            end
            ST_EXP_WAIT:
            begin
                k_next = 3'd0;
            end
            ST_EXP_EMIT:
            begin
                if (mask_reg == '0)
                begin
                    rpush   = room;
                    rs.last = 1'b1;
                end
                else if (!mask_reg[k_reg])
                begin
                    k_next = k_reg + 3'd1;
                end
                else if (room)
                begin
                    rpush     = 1'b1;
                    rs.nvalid = 1'b1;
                    rs.id     = ID_W'(idx + IDX_W'(1));
                    rs.cost   = nb_cost(k_reg);
                    rs.last   = k_last;
                    k_next    = k_reg + 3'd1;
                end
            end
            ST_DIST:
            begin
                rpush       = room;
                rs.dist_x10 = DIST_W'({cmd_reg.dsum, 3'b000}) + DIST_W'({cmd_reg.dsum, 1'b0});
                rs.last     = 1'b1;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            addr_reg    <= '0;
            rd_pend_reg <= 1'b0;
            init_reg    <= 1'b1;
        end
        else
        begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            rd_pend_reg <= rd_pend_next;
            init_reg    <= init_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        row_reg  <= row_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        k_reg    <= k_next;
        rd_k_reg <= rd_k_next;
        mask_reg <= mask_next;
    end

    // result queue
    assign opop  = pop && (of_cnt_reg != 3'd0);
    assign empty = (of_cnt_reg == 3'd0);
    assign res   = of_mem_reg[of_rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            of_wp_reg  <= 2'd0;
            of_rp_reg  <= 2'd0;
            of_cnt_reg <= 3'd0;
        end
        else
        begin
            if (rpush)
            begin
                of_wp_reg <= of_wp_reg + 2'd1;
            end
            if (opop)
            begin
                of_rp_reg <= of_rp_reg + 2'd1;
            end
            of_cnt_reg <= of_cnt_reg + 3'(rpush ? 1 : 0) - 3'(opop ? 1 : 0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rpush)
        begin
            of_mem_reg[of_wp_reg] <= rs;
        end
    end

endmodule

// ===== design/grid_walkability_map_core.sv =====
// Grid walkability map top level: APB registers, front end, back end.
// Back end per item: a query reads its cell, then responds; a distance responds without the RAM;
// an expand reads its on-map neighbor slots, waits, then walks the slots up to the last passable
// one; a fill writes its clipped area cell by cell; a clear writes every RAM cell. The map RAM has
// one read and one write port; one item in the back at a time. After reset the map is swept to
// walkable with full high. Registers reset to zero. Depends on gwm_pkg, gwm_front, gwm_back.
module grid_walkability_map_core #(
    parameter int MAX_WIDTH  = gwm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = gwm_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [gwm_pkg::PADDR_W-1:0]          paddr,
    input  logic [gwm_pkg::DATA_W-1:0]           pwdata,
    output logic [gwm_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready,
    input  logic                                 push,
    output logic                                 full,
    input  logic [gwm_pkg::OP_W-1:0]             op,
    input  logic signed [gwm_pkg::COORD_W-1:0]   x_coord,
    input  logic signed [gwm_pkg::COORD_W-1:0]   y_coord,
    input  logic                                 above_ground,
    input  logic [gwm_pkg::COORD_W-1:0]          half_width,
    input  logic [gwm_pkg::COORD_W-1:0]          half_height,
    input  logic                                 fill_value,
    input  logic signed [gwm_pkg::COORD_W-1:0]   goal_x,
    input  logic signed [gwm_pkg::COORD_W-1:0]   goal_y,
    output logic                                 empty,
    input  logic                                 pop,
    output logic                                 walkable,
    output logic                                 neighbor_valid,
    output logic [gwm_pkg::ID_W-1:0]             neighbor_id,
    output logic [gwm_pkg::COST_W-1:0]           step_cost,
    output logic [gwm_pkg::DIST_W-1:0]           distance,
    output logic                                 last
);
    import gwm_pkg::*;

    logic [DIM_W-1:0] map_width_reg, map_height_reg;
    logic [DIM_W-1:0] eff_w, eff_h;
    logic             wr_en, q_pop, q_empty, hold;
    cmd_t             q_head;
    result_t          res;

    // configuration registers
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= '0;
            map_height_reg <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_WIDTH:  map_width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: map_height_reg <= pwdata[DIM_W-1:0];
                default:    map_width_reg  <= map_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_WIDTH: prdata = DATA_W'(map_width_reg);
            default:   prdata = DATA_W'(map_height_reg);
        endcase
    end

    // dimensions in use, limited to the RAM's shape
    assign eff_w = (32'(map_width_reg) > 32'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : map_width_reg;
    assign eff_h = (32'(map_height_reg) > 32'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                           : map_height_reg;

    gwm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .op           (op),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .above_ground (above_ground),
        .half_width   (half_width),
        .half_height  (half_height),
        .fill_value   (fill_value),
        .goal_x       (goal_x),
        .goal_y       (goal_y),
        .eff_w        (eff_w),
        .eff_h        (eff_h),
        .hold         (hold),
        .q_pop        (q_pop),
        .q_empty      (q_empty),
        .q_head       (q_head)
    );

    gwm_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .eff_w   (eff_w),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .hold    (hold),
        .pop     (pop),
        .empty   (empty),
        .res     (res)
    );

    assign walkable       = res.walkable;
    assign neighbor_valid = res.nvalid;
    assign neighbor_id    = res.id;
    assign step_cost      = res.cost;
    assign distance       = res.dist_x10;
    assign last           = res.last;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for grid_walkability_map_core: queue-style push/pop traffic,
// APB register writes between phases, an in-bench map model predicting every transfer.
// Depends on gwm_pkg and the grid_walkability_map_core RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gwm_pkg::*;

    // up to three clear passes may still be queued once the results are in
    localparam int SWEEP_CYCLES = 198000;
    localparam int CYCLE_LIMIT  = 10000000;

    typedef struct {
        logic [OP_W-1:0]           op;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      ag;
        logic [COORD_W-1:0]        hw;
        logic [COORD_W-1:0]        hh;
        logic                      fv;
        logic signed [COORD_W-1:0] gx;
        logic signed [COORD_W-1:0] gy;
    } cmd_item_t;

    logic clk, rst_n;
    logic psel, penable, pwrite, pready;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata, prdata;
    logic push, full, empty, pop;
    logic [OP_W-1:0] op;
    logic signed [COORD_W-1:0] x_coord, y_coord, goal_x, goal_y;
    logic above_ground, fill_value;
    logic [COORD_W-1:0] half_width, half_height;
    logic walkable, neighbor_valid, last;
    logic [ID_W-1:0] neighbor_id;
    logic [COST_W-1:0] step_cost;
    logic [DIST_W-1:0] distance;

    grid_walkability_map_core i_dut (.*);

    // map model and its registers
    bit          walk_map [0:65535];
    int          cols_reg, rows_reg;
    cmd_item_t   cmd_pending[$];
    cmd_item_t   cmd_active;
    result_t     result_expected[$];
    int          error_count;
    int          transfers_seen;
    int          send_gap, recv_gap, recv_hold;
    bit          send_burst, recv_burst;
    int          cycle_count;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit map_open(int cx, int cy);
        int w, h;
        w = (cols_reg > 256) ? 256 : cols_reg;
        h = (rows_reg > 256) ? 256 : rows_reg;
        if (cx < 0 || cy < 0 || cx >= w || cy >= h) return 1'b0;
        return walk_map[cy * w + cx];
    endfunction

    // append one predicted transfer
    function automatic void queue_result(input result_t r);
        result_expected = {result_expected, r};
    endfunction

    // update the map and queue the transfers one command yields
    task automatic predict_map(input cmd_item_t c);
        int w, h, cx, cy, x0, x1, y0, y1, n, ax, ay;
        result_t r;
        w = (cols_reg > 256) ? 256 : cols_reg;
        h = (rows_reg > 256) ? 256 : rows_reg;
        cx = int'(c.x);
        cy = int'(c.y);
        r = '0;
        case (c.op)
            OP_CLEAR: for (int i = 0; i < 65536; i++) walk_map[i] = 1'b1;
            OP_FILL: if (!c.ag) begin
                x0 = cx - int'(c.hw); x1 = cx + int'(c.hw);
                y0 = cy - int'(c.hh); y1 = cy + int'(c.hh);
                if (x0 < 0) x0 = 0;
                if (y0 < 0) y0 = 0;
                if (x1 > w - 1) x1 = w - 1;
                if (y1 > h - 1) y1 = h - 1;
                for (int i = x0; i <= x1; i++)
                    for (int j = y0; j <= y1; j++)
                        walk_map[j * w + i] = c.fv;
            end
            OP_QUERY: begin
                r.walkable = !c.ag && map_open(cx, cy);
                r.last = 1'b1;
                queue_result(r);
            end
            OP_EXPAND: begin
                n = 0;
                for (int dx = -1; dx <= 1; dx++)
                    for (int dy = -1; dy <= 1; dy++) begin
                        if ((dx != 0 || dy != 0) && map_open(cx + dx, cy + dy)) begin
                            r = '0;
                            r.nvalid = 1'b1;
                            r.id = ID_W'((cy + dy) * w + (cx + dx) + 1);
                            r.cost = (dx == 0 || dy == 0) ? COST_STRAIGHT : COST_DIAG;
                            queue_result(r);
                            n++;
                        end
                    end
                if (n == 0) begin
                    r = '0;
                    r.last = 1'b1;
                    queue_result(r);
                end else begin
                    result_expected[$].last = 1'b1;
                end
            end
            OP_DIST: begin
                ax = (cx > int'(c.gx)) ? cx - int'(c.gx) : int'(c.gx) - cx;
                ay = (cy > int'(c.gy)) ? cy - int'(c.gy) : int'(c.gy) - cy;
                r.dist_x10 = DIST_W'((ax + ay) * 10);
                r.last = 1'b1;
                queue_result(r);
            end
            default: ;
        endcase
    endtask

    // driver: one command per transfer, random gaps between them
    always @(posedge clk) begin
        cmd_item_t c;
        if (rst_n) begin
            if (push && !full) predict_map(cmd_active);
            if (!push || !full) begin
                if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
                if (send_gap > 0) begin
                    send_gap--;
                    push <= 1'b0;
                end else if (cmd_pending.size() > 0) begin
                    c = cmd_pending.pop_front();
                    cmd_active = c;
                    op <= c.op; x_coord <= c.x; y_coord <= c.y; above_ground <= c.ag;
                    half_width <= c.hw; half_height <= c.hh; fill_value <= c.fv;
                    goal_x <= c.gx; goal_y <= c.gy;
                    push <= 1'b1;
                    if (send_burst) send_gap = 0;
                    else if ($urandom_range(0, 9) < 6) send_gap = 0;
                    else if ($urandom_range(0, 9) < 8) send_gap = $urandom_range(1, 3);
                    else send_gap = $urandom_range(10, 40);
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result transfer against the oldest prediction
    always @(posedge clk) begin
        result_t e;
        if (rst_n) begin
            if (pop && !empty) begin
                transfers_seen++;
                if (result_expected.size() == 0) begin
                    $display("%0t: unexpected result, actual walk=%0b valid=%0b id=%0d",
                             $time, walkable, neighbor_valid, neighbor_id);
                    $display("%0t:   cost=%0d dist=%0d last=%0b",
                             $time, step_cost, distance, last);
                    error_count++;
                end else begin
                    e = result_expected.pop_front();
                    if (walkable !== e.walkable) begin
                        $display("%0t: walkable expected %0b actual %0b", $time, e.walkable, walkable);
                        error_count++;
                    end
                    if (neighbor_valid !== e.nvalid) begin
                        $display("%0t: neighbor_valid expected %0b actual %0b",
                                 $time, e.nvalid, neighbor_valid);
                        error_count++;
                    end
                    if (neighbor_id !== e.id) begin
                        $display("%0t: neighbor_id expected %0d actual %0d", $time, e.id, neighbor_id);
                        error_count++;
                    end
                    if (step_cost !== e.cost) begin
                        $display("%0t: step_cost expected %0d actual %0d", $time, e.cost, step_cost);
                        error_count++;
                    end
                    if (distance !== e.dist_x10) begin
                        $display("%0t: distance expected %0d actual %0d",
                                 $time, e.dist_x10, distance);
                        error_count++;
                    end
                    if (last !== e.last) begin
                        $display("%0t: last expected %0b actual %0b", $time, e.last, last);
                        error_count++;
                    end
                end
                // one long hold-off so the block backs up into its input
                if (transfers_seen == 30) recv_hold = 600;
            end
            if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
            if (recv_hold > 0) begin
                recv_hold--;
                pop <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                if (!recv_burst && $urandom_range(0, 9) < 3)
                    recv_gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                         : $urandom_range(10, 50);
            end
        end
    end

    // run limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic add_cmd(input logic [OP_W-1:0] o, input int cx, input int cy,
                           input bit ag, input int hw, input int hh, input bit fv,
                           input int gx, input int gy);
        cmd_item_t c;
        c.op = o; c.x = COORD_W'(cx); c.y = COORD_W'(cy); c.ag = ag;
        c.hw = COORD_W'(hw); c.hh = COORD_W'(hh);
        c.fv = fv; c.gx = COORD_W'(gx); c.gy = COORD_W'(gy);
        cmd_pending = {cmd_pending, c};
    endtask

    // sampled away from the active edge so queue and push updates are settled
    task automatic wait_drained();
        @(negedge clk);
        while (cmd_pending.size() > 0 || push || result_expected.size() > 0)
            @(negedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input int value);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_map_size(input int w, input int h);
        apb_write(PADDR_W'(4 * REG_WIDTH), w);
        apb_write(PADDR_W'(4 * REG_HEIGHT), h);
        cols_reg = w & 9'h1FF;
        rows_reg = h & 9'h1FF;
    endtask

    // random command: mostly near the map, some anywhere in the 16-bit range
    task automatic add_random_cmd();
        int w, h, roll, cx, cy, hw, hh;
        logic [OP_W-1:0] o;
        w = (cols_reg > 256) ? 256 : cols_reg;
        h = (rows_reg > 256) ? 256 : rows_reg;
        roll = $urandom_range(0, 99);
        if (roll < 28) o = OP_QUERY;
        else if (roll < 58) o = OP_EXPAND;
        else if (roll < 72) o = OP_DIST;
        else if (roll < 94) o = OP_FILL;
        else if (roll < 95) o = OP_CLEAR;
        else o = OP_W'($urandom_range(5, 7));
        if ($urandom_range(0, 9) < 8) begin
            cx = $urandom_range(0, w + 3) - 2;
            cy = $urandom_range(0, h + 3) - 2;
        end else begin
            cx = $signed(16'($urandom));
            cy = $signed(16'($urandom));
        end
        if (w * h <= 4096 && $urandom_range(0, 4) == 0) begin
            hw = $urandom_range(0, 65535);
            hh = $urandom_range(0, 65535);
        end else begin
            hw = $urandom_range(0, 3);
            hh = $urandom_range(0, 3);
        end
        add_cmd(o, cx, cy, $urandom_range(0, 3) == 0, hw, hh, $urandom_range(0, 2) != 0,
                $signed(16'($urandom)), $signed(16'($urandom)));
    endtask

    initial begin
        int widths[6], heights[6];
        widths  = '{8, 0, 1, 511, 256, 37};
        heights = '{6, 0, 1, 3, 256, 300};
        rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        push = 0; pop = 0; op = OP_QUERY; x_coord = 0; y_coord = 0; above_ground = 0;
        half_width = 0; half_height = 0; fill_value = 0; goal_x = 0; goal_y = 0;
        cols_reg = 0; rows_reg = 0; error_count = 0; transfers_seen = 0;
        send_gap = 0; recv_gap = 0; recv_hold = 0; send_burst = 0; recv_burst = 0;
        cycle_count = 0;
        for (int i = 0; i < 65536; i++) walk_map[i] = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                wait_drained();
                repeat (SWEEP_CYCLES) @(posedge clk);
            end
            set_map_size(widths[p], heights[p]);
            if (p == 0) begin
                // directed: 8x6 map
                add_cmd(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0);
                add_cmd(OP_FILL, 3, 2, 0, 1, 1, 0, 0, 0);        // block a 3x3 patch
                add_cmd(OP_EXPAND, 3, 2, 0, 0, 0, 0, 0, 0);      // fully enclosed cell
                add_cmd(OP_QUERY, 3, 2, 0, 0, 0, 0, 0, 0);
                add_cmd(OP_QUERY, 5, 2, 1, 0, 0, 0, 0, 0);       // above ground
                add_cmd(OP_FILL, 0, 0, 1, 9, 9, 0, 0, 0);        // fill above ground ignored
                add_cmd(OP_EXPAND, 0, 0, 1, 0, 0, 0, 0, 0);      // corner
                add_cmd(OP_EXPAND, 7, 5, 0, 0, 0, 0, 0, 0);
                add_cmd(OP_EXPAND, -1, -1, 0, 0, 0, 0, 0, 0);    // center off the map
                add_cmd(OP_EXPAND, 8, 6, 0, 0, 0, 0, 0, 0);
                add_cmd(OP_QUERY, -32768, 32767, 0, 0, 0, 0, 0, 0);
                add_cmd(OP_QUERY, 8, 5, 0, 0, 0, 0, 0, 0);
                add_cmd(OP_DIST, -32768, -32768, 1, 0, 0, 0, 32767, 32767);
                add_cmd(OP_DIST, 32767, 0, 0, 0, 0, 0, 32767, 0);
                add_cmd(OP_FILL, -32768, 32767, 0, 65535, 65535, 0, 0, 0);
                add_cmd(OP_EXPAND, 4, 4, 0, 0, 0, 0, 0, 0);
                add_cmd(OP_FILL, 2, 2, 0, 0, 0, 1, 0, 0);
                add_cmd(OP_EXPAND, 2, 3, 0, 0, 0, 0, 0, 0);
                add_cmd(3'd5, 1, 1, 0, 0, 0, 0, 0, 0);
                add_cmd(3'd7, 1, 1, 0, 0, 0, 0, 0, 0);
                add_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
                add_cmd(OP_EXPAND, 3, 2, 0, 0, 0, 0, 0, 0);
            end
            for (int k = 0; k < 42; k++) begin
                // sender pause until the block has delivered everything
                if (p == 2 && k == 20) wait_drained();
                add_random_cmd();
            end
        end

        wait_drained();
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
